// ===== design/assert_macros.svh =====
// Shared assertion macros; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on aclk, off during reset
`define CHRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on aclk, off during reset
`define CHRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CHRS_ASSERT_IMP(lbl, ante, cons)
`define CHRS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== design/chrs_pkg.sv =====
package chrs_pkg;

    localparam int DW    = 32;  // input data width
    localparam int UW    = 31;  // unsigned coefficient width
    localparam int MW    = 64;  // multiplier operand and result width
    localparam int FW    = 48;  // flux and rate width
    localparam int SH_W  = 7;

    // configuration register indexes
    localparam logic [1:0] REG_GRID_WIDTH = 2'd0;
    localparam logic [1:0] REG_INV_DX2    = 2'd1;
    localparam logic [1:0] REG_INV_DX4    = 2'd2;

    typedef struct packed {
        logic                  start;
        logic [SH_W-1:0]       sh;
    } mul_req_t;

    // one line-store entry
    typedef struct packed {
        logic signed [DW-1:0]  conc;
        logic signed [FW-1:0]  flux;
        logic [UW-1:0]         eps;
        logic [UW-1:0]         sigma;
        logic signed [DW-1:0]  mean;
    } chrs_word_t;

    function automatic logic signed [FW-1:0] sat48(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] hi;
        logic signed [MW-1:0] lo;
        hi = (MW'(1) <<< (FW - 1)) - MW'(1);
        lo = -hi - MW'(1);
        if (v > hi) begin
            return hi[FW-1:0];
        end else if (v < lo) begin
            return lo[FW-1:0];
        end
        return v[FW-1:0];
    endfunction

endpackage

// ===== design/chrs_line_ram.sv =====
module chrs_line_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/chrs_mul.sv =====
`include "assert_macros.svh"

// Signed multiply, shift right toward zero, saturate to 62 bits.
// Four 32x32 partial products, one per cycle; done rises in the same cycle that the product becomes valid.
module chrs_mul (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  chrs_pkg::mul_req_t                req,
    input  logic signed [chrs_pkg::MW-1:0]    op_a,
    input  logic signed [chrs_pkg::MW-1:0]    op_b,
    output logic                              done,
    output logic signed [chrs_pkg::MW-1:0]    product
);

    localparam int MW = chrs_pkg::MW;
    localparam int HW = MW / 2;
    localparam int AW = 2 * MW;
    localparam logic [AW-1:0] LIM = AW'(1) << 61;

    logic                       busy_reg, busy_next;
    logic [2:0]                 step_reg, step_next;
    logic                       done_reg, done_next;
    logic                       neg_reg;
    logic [MW-1:0]              ma_reg, mb_reg;
    logic [chrs_pkg::SH_W-1:0]  sh_reg;
    logic [MW-1:0]              pp_reg;
    logic [AW-1:0]              acc_reg;
    logic [AW-1:0]              shifted_reg;
    logic signed [MW-1:0]       prod_reg;

    logic [HW-1:0]  a_part, b_part;
    logic [1:0]     acc_idx;
    logic [AW-1:0]  pp_ext;
    logic [MW-1:0]  mag;
    logic           pos_over, neg_over;

    always_comb begin
        a_part  = step_reg[0] ? ma_reg[MW-1:HW] : ma_reg[HW-1:0];
        b_part  = step_reg[1] ? mb_reg[MW-1:HW] : mb_reg[HW-1:0];
        acc_idx = 2'(step_reg - 3'd1);
        case (acc_idx)
            2'd0:    pp_ext = AW'(pp_reg);
            2'd3:    pp_ext = AW'(pp_reg) << MW;
            default: pp_ext = AW'(pp_reg) << HW;
        endcase
        pos_over = shifted_reg[AW-1:61] != '0;
        neg_over = (shifted_reg[AW-1:62] != '0) || (shifted_reg[61] && shifted_reg[60:0] != '0);
        if (neg_reg) begin
            mag = neg_over ? MW'(LIM) : MW'(shifted_reg[61:0]);
        end else begin
            mag = pos_over ? MW'(LIM - AW'(1)) : MW'(shifted_reg[60:0]);
        end
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = 3'd0;
        end else if (busy_reg) begin
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd6) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg <= op_a[MW-1] ^ op_b[MW-1];
            ma_reg  <= op_a[MW-1] ? MW'(-op_a) : MW'(op_a);
            mb_reg  <= op_b[MW-1] ? MW'(-op_b) : MW'(op_b);
            sh_reg  <= req.sh;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg < 3'd4) begin
                pp_reg <= MW'(a_part) * MW'(b_part);
            end
            if (step_reg >= 3'd1 && step_reg <= 3'd4) begin
                acc_reg <= acc_reg + pp_ext;
            end
            if (step_reg == 3'd5) begin
                shifted_reg <= acc_reg >> sh_reg;
            end
            if (step_reg == 3'd6) begin
                prod_reg <= neg_reg ? -$signed(mag) : $signed(mag);
            end
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

    `CHRS_ASSERT_IMP(a_start_when_free, req.start, !busy_reg)
    `CHRS_ASSERT_NXT(a_start_sets_busy, req.start, busy_reg)

endmodule

// ===== design/cahn_hilliard_rate_stencil_core.sv =====
// Cahn-Hilliard rate stencil, one cell transaction at a time.
// Edge cell: four products on the shared multiplier, then a write-back. Interior cell:
// twelve line-store reads, eight products, write-back and output load; a result still
// waiting holds the next transaction back.
// Reset (aresetn low, synchronous): frame position 0, grid width MAX_GRID, scales 1.0.
`include "assert_macros.svh"

module cahn_hilliard_rate_stencil_core #(
    parameter int MAX_GRID = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    // concentration, cubic_coef, linear_coef, fourth_order_coef, relax_rate,
    // target_value, zero pad
    input  logic [191:0]  s_tdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // row, col, rate_of_change
    output logic [63:0]   m_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic          m_tlast,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [39:0]   cfg_wr_data
);

    localparam int DW   = chrs_pkg::DW;
    localparam int UW   = chrs_pkg::UW;
    localparam int MW   = chrs_pkg::MW;
    localparam int FW   = chrs_pkg::FW;
    localparam int CW   = $clog2(MAX_GRID);
    localparam int GWW  = $clog2(MAX_GRID + 1);
    localparam int DEPTH = 4 * MAX_GRID;
    localparam int RAW  = $clog2(DEPTH);
    localparam int BW   = 40;
    localparam int LW   = 52;
    localparam int WW   = $bits(chrs_pkg::chrs_word_t);

    localparam logic [1:0] REG_GRID_WIDTH = chrs_pkg::REG_GRID_WIDTH;
    localparam logic [1:0] REG_INV_DX2    = chrs_pkg::REG_INV_DX2;
    localparam logic [1:0] REG_INV_DX4    = chrs_pkg::REG_INV_DX4;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [2:0] OP_C2 = 3'd0;
    localparam logic [2:0] OP_C3 = 3'd1;
    localparam logic [2:0] OP_UC = 3'd2;
    localparam logic [2:0] OP_BC = 3'd3;
    localparam logic [2:0] OP_LT = 3'd4;
    localparam logic [2:0] OP_E1 = 3'd5;
    localparam logic [2:0] OP_BT = 3'd6;
    localparam logic [2:0] OP_RT = 3'd7;

    localparam logic [3:0] RD_LAST = 4'd11;
    localparam logic [3:0] RD_DONE = 4'd12;

    // control
    logic [2:0]      state_reg, state_next;
    logic [2:0]      op_reg, op_next;
    logic [CW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [GWW-1:0]  gw_reg, gw_next;
    logic [39:0]     inv2_reg, inv4_reg;
    logic [3:0]      rd_k_reg, rd_k_next;
    logic            rd_vld_reg;
    logic [3:0]      rd_kd_reg;
    logic            emit_reg, emit_next;
    logic            m_tvalid_reg, m_tvalid_next;

    // payload
    logic signed [DW-1:0]  cv_reg, uv_reg, bv_reg, mv_reg;
    logic [UW-1:0]         ev_reg, sv_reg;
    logic                  last_reg;
    logic [7:0]            row_out_reg, col_out_reg;
    logic signed [BW-1:0]  bacc_reg;
    logic signed [LW-1:0]  lap_reg;
    logic signed [DW-1:0]  cc_reg, mean_reg;
    logic [UW-1:0]         eps_reg, sigma_reg;
    logic signed [MW-1:0]  c2_reg, c3_reg, p1_reg, lt_reg, e1_reg, bt_reg;
    logic signed [FW-1:0]  g_reg, rate_reg;
    logic [63:0]           m_tdata_reg;
    logic                  m_tlast_reg;

    logic                  rd_issue, ram_we, out_load, accept;
    logic [1:0]            rd_slot;
    logic [CW-1:0]         rd_col;
    logic [RAW-1:0]        rd_addr, wr_addr;
    logic [WW-1:0]         rd_raw;
    chrs_pkg::chrs_word_t  rd_word, wr_word;
    chrs_pkg::mul_req_t    mul_req;
    logic signed [MW-1:0]  mul_a, mul_b, mul_p;
    logic                  mul_done;
    logic signed [DW:0]    rel_diff;
    logic signed [BW-1:0]  cx;
    logic signed [LW-1:0]  fx;
    logic [8:0]            cfg_w;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = state_reg == ST_IDLE;
    assign rd_issue = state_reg == ST_RD && rd_k_reg != RD_DONE;
    assign ram_we   = state_reg == ST_WR;
    assign out_load = state_reg == ST_OUT && (!m_tvalid_reg || m_tready);
    assign rd_word  = chrs_pkg::chrs_word_t'(rd_raw);
    assign cx       = BW'(rd_word.conc);
    assign fx       = LW'(rd_word.flux);
    assign rel_diff = (DW + 1)'(cc_reg) - (DW + 1)'(mean_reg);
    assign cfg_w    = cfg_wr_data[8:0];

    // read plan: slots count from the row two above the center
    always_comb begin
        rd_slot = 2'd2;
        rd_col  = col_reg;
        case (rd_k_reg)
            4'd0:  rd_slot = 2'd0;
            4'd1:  rd_slot = 2'd1;
            4'd2:  rd_slot = 2'd3;
            4'd3:  rd_col  = col_reg - CW'(1);
            4'd4:  rd_col  = col_reg + CW'(1);
            4'd5:  rd_col  = col_reg - CW'(2);
            4'd6:  rd_col  = col_reg + CW'(2);
            4'd7:  begin rd_slot = 2'd1; rd_col = col_reg - CW'(1); end
            4'd8:  begin rd_slot = 2'd1; rd_col = col_reg + CW'(1); end
            4'd9:  begin rd_slot = 2'd3; rd_col = col_reg - CW'(1); end
            4'd10: begin rd_slot = 2'd3; rd_col = col_reg + CW'(1); end
            default: ;
        endcase
        rd_addr = RAW'(2'(row_reg[1:0] + rd_slot)) * RAW'(MAX_GRID) + RAW'(rd_col);
        wr_addr = RAW'(row_reg[1:0]) * RAW'(MAX_GRID) + RAW'(col_reg);
    end

    always_comb begin
        wr_word.conc  = cv_reg;
        wr_word.flux  = g_reg;
        wr_word.eps   = ev_reg;
        wr_word.sigma = sv_reg;
        wr_word.mean  = mv_reg;
    end

    chrs_line_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    always_comb begin
        mul_a = 64'(cv_reg);
        mul_b = 64'(cv_reg);
        mul_req.start = state_reg == ST_MUL;
        mul_req.sh    = 7'd28;
        case (op_reg)
            OP_C2: ;
            OP_C3: mul_a = c2_reg;
            OP_UC: begin mul_a = 64'(uv_reg); mul_b = c3_reg; mul_req.sh = 7'd20; end
            OP_BC: begin mul_a = 64'(bv_reg); mul_req.sh = 7'd20; end
            OP_LT: begin mul_a = 64'(lap_reg); mul_b = 64'(inv2_reg); mul_req.sh = 7'd16; end
            OP_E1: begin mul_a = 64'(eps_reg); mul_b = 64'(bacc_reg); mul_req.sh = 7'd24; end
            OP_BT: begin mul_a = e1_reg; mul_b = 64'(inv4_reg); mul_req.sh = 7'd12; end
            OP_RT: begin mul_a = 64'(sigma_reg); mul_b = 64'(rel_diff); mul_req.sh = 7'd20; end
            default: ;
        endcase
    end

    chrs_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        gw_next       = gw_reg;
        rd_k_next     = rd_k_reg;
        emit_next     = emit_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    emit_next = 32'(row_reg) >= 4 && 32'(col_reg) >= 2
                                && 32'(col_reg) + 3 <= 32'(gw_reg);
                    op_next   = OP_C2;
                    rd_k_next = 4'd0;
                    state_next = emit_next ? ST_RD : ST_MUL;
                end
            end
            ST_RD: begin
                if (rd_issue) begin
                    rd_k_next = rd_k_reg + 4'd1;
                end
                if (rd_vld_reg && rd_kd_reg == RD_LAST) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_WAIT;
            ST_WAIT: begin
                if (mul_done) begin
                    if (op_reg == OP_RT || (op_reg == OP_BC && !emit_reg)) begin
                        state_next = ST_WR;
                    end else begin
                        op_next    = op_reg + 3'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_WR: begin
                // advance raster position
                if (32'(col_reg) + 1 >= 32'(gw_reg)) begin
                    col_next = '0;
                    row_next = (32'(row_reg) + 1 >= 32'(gw_reg)) ? '0 : row_reg + CW'(1);
                end else begin
                    col_next = col_reg + CW'(1);
                end
                state_next = emit_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_wr_en && cfg_index == REG_GRID_WIDTH) begin
            if (cfg_w < 9'd5) begin
                gw_next = GWW'(5);
            end else if (32'(cfg_w) > MAX_GRID) begin
                gw_next = GWW'(MAX_GRID);
            end else begin
                gw_next = GWW'(cfg_w);
            end
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_C2;
            row_reg      <= '0;
            col_reg      <= '0;
            gw_reg       <= GWW'(MAX_GRID);
            inv2_reg     <= 40'd65536;
            inv4_reg     <= 40'd65536;
            rd_k_reg     <= 4'd0;
            rd_vld_reg   <= 1'b0;
            rd_kd_reg    <= 4'd0;
            emit_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            gw_reg       <= gw_next;
            rd_k_reg     <= rd_k_next;
            rd_vld_reg   <= rd_issue;
            rd_kd_reg    <= rd_k_reg;
            emit_reg     <= emit_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en && cfg_index == REG_INV_DX2) begin
                inv2_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_index == REG_INV_DX4) begin
                inv4_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cv_reg   <= s_tdata[31:0];
            uv_reg   <= s_tdata[63:32];
            bv_reg   <= s_tdata[95:64];
            ev_reg   <= s_tdata[126:96];
            sv_reg   <= s_tdata[157:127];
            mv_reg   <= s_tdata[189:158];
            last_reg <= 32'(row_reg) + 1 == 32'(gw_reg) && 32'(col_reg) + 3 == 32'(gw_reg);
            // the cell two rows below the center enters the axial term directly
            bacc_reg <= BW'($signed(s_tdata[31:0]));
            lap_reg  <= '0;
        end
        if (rd_vld_reg) begin
            case (rd_kd_reg)
                4'd0, 4'd5, 4'd6: bacc_reg <= bacc_reg + cx;
                4'd1, 4'd2, 4'd3, 4'd4: begin
                    bacc_reg <= bacc_reg - (cx <<< 3);
                    lap_reg  <= lap_reg + fx;
                end
                4'd7, 4'd8, 4'd9, 4'd10: bacc_reg <= bacc_reg + (cx <<< 1);
                RD_LAST: begin
                    bacc_reg  <= bacc_reg + (cx <<< 4) + (cx <<< 2);
                    lap_reg   <= lap_reg - (fx <<< 2);
                    cc_reg    <= rd_word.conc;
                    eps_reg   <= rd_word.eps;
                    sigma_reg <= rd_word.sigma;
                    mean_reg  <= rd_word.mean;
                end
                default: ;
            endcase
        end
        if (state_reg == ST_WAIT && mul_done) begin
            case (op_reg)
                OP_C2: c2_reg <= mul_p;
                OP_C3: c3_reg <= mul_p;
                OP_UC: p1_reg <= mul_p;
                OP_BC: g_reg  <= chrs_pkg::sat48(p1_reg - mul_p);
                OP_LT: lt_reg <= mul_p;
                OP_E1: e1_reg <= mul_p;
                OP_BT: bt_reg <= mul_p;
                OP_RT: rate_reg <= chrs_pkg::sat48(lt_reg - bt_reg - mul_p);
                default: ;
            endcase
        end
        if (ram_we) begin
            row_out_reg <= 8'(row_reg - CW'(2));
            col_out_reg <= 8'(col_reg);
        end
        if (out_load) begin
            m_tdata_reg <= {rate_reg, col_out_reg, row_out_reg};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;

    `CHRS_ASSERT_NXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE)
    `CHRS_ASSERT_IMP(a_out_no_overwrite, out_load, !m_tvalid_reg || m_tready)
    `CHRS_ASSERT_IMP(a_ram_rw_excl, ram_we, !rd_issue && !rd_vld_reg)

endmodule
